// ===== rtl/core/lrarb_pkg.sv =====
// shared types and constants for the line ring arbiter
package lrarb_pkg;

  // station count and the index width it needs
  localparam int STATION_COUNT = 8;
  localparam int IDX_W        = (STATION_COUNT > 1) ? $clog2(STATION_COUNT) : 1;

  // widths of the word fields
  localparam int TIME_W   = 32;
  localparam int BITS_W   = 8;
  localparam int STATES_W = 24;
  localparam int GAP_W    = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SILENCE_GAP  = 2'd0,
    REG_AMBIENCE_GAP = 2'd1,
    REG_AMBIENCE_MASK = 2'd2
  } cfg_reg_t;

  // configuration reset values
  localparam logic [GAP_W-1:0]  SILENCE_GAP_RST  = 16'd2000;
  localparam logic [GAP_W-1:0]  AMBIENCE_GAP_RST = 16'd10000;
  localparam logic [BITS_W-1:0] AMBIENCE_MASK_RST = 8'd0;

  // time differences below this limit count as elapsed
  localparam logic [TIME_W-1:0] GAP_LIMIT = 32'h7FFF_FFFF;

  // station modes
  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_WAIT = 3'd1,
    MODE_PLAY = 3'd2,
    MODE_TALK = 3'd3,
    MODE_HANG = 3'd4
  } mode_t;

  // what one lane reports to the merge stage
  typedef struct packed {
    mode_t              mode_cur;
    mode_t              mode_mid;
    mode_t              mode_next;
    logic               leave_play;
    logic [TIME_W-1:0]  age;
  } lane_status_t;

  // merged ringer decision
  typedef struct packed {
    logic             started;
    logic             busy;
    logic [IDX_W-1:0] slot;
  } arb_result_t;

endpackage

// ===== rtl/core/lrarb_if.sv =====
// valid/ready channels carrying the tick word and the result word

interface lrarb_tick_if;
  logic                              valid;
  logic                              ready;
  logic [lrarb_pkg::TIME_W-1:0]      now_ms;
  logic [lrarb_pkg::BITS_W-1:0]      called_bits;
  logic [lrarb_pkg::BITS_W-1:0]      hook_bits;
  logic                              code_playing;

  modport source (output valid, now_ms, called_bits, hook_bits, code_playing, input ready);
  modport sink   (input valid, now_ms, called_bits, hook_bits, code_playing, output ready);
endinterface

interface lrarb_result_if;
  logic                              valid;
  logic                              ready;
  logic [lrarb_pkg::STATES_W-1:0]    mode_word;
  logic                              ringer_valid;
  logic [2:0]                        ringer_index;
  logic                              ring_started;

  modport source (output valid, mode_word, ringer_valid, ringer_index, ring_started,
                  input ready);
  modport sink   (input valid, mode_word, ringer_valid, ringer_index, ring_started,
                  output ready);
endinterface

// ===== rtl/core/lrarb_lane.sv =====
// one station lane: mode state machine and wait start time
module lrarb_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [lrarb_pkg::TIME_W-1:0]  now_ms,
  input  logic                          called,
  input  logic                          hook,
  input  logic                          code_playing,
  input  logic                          ambience,
  input  logic                          grant,
  output lrarb_pkg::lane_status_t       status
);

  lrarb_pkg::mode_t              mode;
  lrarb_pkg::mode_t              mode_mid;
  lrarb_pkg::mode_t              mode_next;
  logic [lrarb_pkg::TIME_W-1:0]  wait_start;
  logic                          enter_wait;

  // per-tick transitions before arbitration
  always_comb begin
    mode_mid = mode;
    case (mode)
      lrarb_pkg::MODE_WAIT: begin
        if (!called)    mode_mid = lrarb_pkg::MODE_IDLE;
        else if (hook)  mode_mid = lrarb_pkg::MODE_TALK;
      end
      lrarb_pkg::MODE_PLAY: begin
        if (!called)            mode_mid = lrarb_pkg::MODE_IDLE;
        else if (hook)          mode_mid = lrarb_pkg::MODE_TALK;
        else if (!code_playing) mode_mid = ambience ? lrarb_pkg::MODE_IDLE
                                                    : lrarb_pkg::MODE_WAIT;
      end
      lrarb_pkg::MODE_TALK: begin
        if (!called || !hook) mode_mid = lrarb_pkg::MODE_HANG;
      end
      lrarb_pkg::MODE_HANG: begin
        if (!called && !hook) mode_mid = lrarb_pkg::MODE_IDLE;
      end
      default: begin
        if (called)     mode_mid = lrarb_pkg::MODE_WAIT;
        else if (hook)  mode_mid = lrarb_pkg::MODE_TALK;
      end
    endcase
  end

  // a granted lane starts ringing
  assign mode_next  = grant ? lrarb_pkg::MODE_PLAY : mode_mid;
  assign enter_wait = (mode_mid == lrarb_pkg::MODE_WAIT) && (mode != lrarb_pkg::MODE_WAIT);

  // report to the merge stage; a fresh wait has age zero
  assign status.mode_cur   = mode;
  assign status.mode_mid   = mode_mid;
  assign status.mode_next  = mode_next;
  assign status.leave_play = (mode == lrarb_pkg::MODE_PLAY) &&
                             (mode_mid != lrarb_pkg::MODE_PLAY);
  assign status.age        = enter_wait ? '0 : (now_ms - wait_start);

  // lane state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= lrarb_pkg::MODE_IDLE;
    end else if (en) begin
      mode <= mode_next;
    end
  end

  // wait start stamp, only read while waiting
  always_ff @(posedge clk) begin
    if (en && enter_wait) begin
      wait_start <= now_ms;
    end
  end

endmodule

// ===== rtl/core/lrarb_merge.sv =====
// merge stage: gap checks and oldest-waiting pick over all lanes
module lrarb_merge (
  input  lrarb_pkg::lane_status_t                 lanes [lrarb_pkg::STATION_COUNT],
  input  logic [lrarb_pkg::STATION_COUNT-1:0]     ambience,
  input  logic [lrarb_pkg::TIME_W-1:0]            now_ms,
  input  logic [lrarb_pkg::TIME_W-1:0]            last_end,
  input  logic [lrarb_pkg::GAP_W-1:0]             silence_gap,
  input  logic [lrarb_pkg::GAP_W-1:0]             ambience_gap,
  output logic [lrarb_pkg::STATION_COUNT-1:0]     grant,
  output lrarb_pkg::arb_result_t                  res
);

  localparam int NP = 1 << lrarb_pkg::IDX_W;

  typedef struct packed {
    logic [lrarb_pkg::TIME_W-1:0] age;
    logic [lrarb_pkg::IDX_W-1:0]  idx;
  } node_t;

  // lower index wins unless the right side is strictly older
  function automatic node_t pick(input node_t a, input node_t b);
    pick = (b.age > a.age) ? b : a;
  endfunction

  logic [lrarb_pkg::TIME_W-1:0]        elapsed;
  logic                                silence_ok;
  logic                                ambience_ok;
  logic                                busy_mid;
  logic                                normal_idle;
  logic [lrarb_pkg::IDX_W-1:0]         play_idx;
  logic [lrarb_pkg::STATION_COUNT-1:0] cand;
  logic                                started;
  node_t                               nodes [2*NP-1];

  // time since the last ring ended, signed window
  assign elapsed     = now_ms - last_end;
  assign silence_ok  = ({16'd0, silence_gap} < elapsed) && (elapsed < lrarb_pkg::GAP_LIMIT);
  assign ambience_ok = ({16'd0, ambience_gap} < elapsed) && (elapsed < lrarb_pkg::GAP_LIMIT);

  // ringer presence and normal-station idleness after the lane step
  always_comb begin
    busy_mid    = 1'b0;
    normal_idle = 1'b1;
    play_idx    = '0;
    for (int i = 0; i < lrarb_pkg::STATION_COUNT; i++) begin
      if (lanes[i].mode_mid == lrarb_pkg::MODE_PLAY) begin
        busy_mid = 1'b1;
        play_idx = play_idx | lrarb_pkg::IDX_W'(i);
      end
      if (!ambience[i] && (lanes[i].mode_mid != lrarb_pkg::MODE_IDLE)) begin
        normal_idle = 1'b0;
      end
    end
  end

  // candidates and tree leaves
  for (genvar i = 0; i < NP; i++) begin : g_leaf
    if (i < lrarb_pkg::STATION_COUNT) begin : g_real
      assign cand[i] = (lanes[i].mode_mid == lrarb_pkg::MODE_WAIT) &&
                       (!ambience[i] || (normal_idle && ambience_ok));
      assign nodes[NP-1+i].age = cand[i] ? lanes[i].age : '0;
    end else begin : g_pad
      assign nodes[NP-1+i].age = '0;
    end
    assign nodes[NP-1+i].idx = lrarb_pkg::IDX_W'(i);
  end

  // oldest-waiting reduction tree
  for (genvar k = 0; k < NP-1; k++) begin : g_node
    assign nodes[k] = pick(nodes[2*k+1], nodes[2*k+2]);
  end

  // a zero age never wins
  assign started = !busy_mid && silence_ok && (nodes[0].age != '0);

  for (genvar i = 0; i < lrarb_pkg::STATION_COUNT; i++) begin : g_grant
    assign grant[i] = started && (nodes[0].idx == lrarb_pkg::IDX_W'(i));
  end

  assign res.started = started;
  assign res.busy    = busy_mid || started;
  assign res.slot    = started ? nodes[0].idx : play_idx;

endmodule

// ===== rtl/core/line_ring_arbiter.sv =====
// line ring arbiter top level: station lanes, merge stage and result register
//
// Each tick word carries the millisecond time, the called and off-hook bits
// of every station and the code-playing flag. The block answers each tick
// word with exactly one result word: the three-bit mode of every station,
// the station now ringing and whether a new ringer was chosen on this tick.
// Configuration (silence gap, ambience gap, ambience mask) is written over
// cfg_we / cfg_index / cfg_data; the user must write it only while no tick
// is in flight, which the block does not enforce. The result word is
// registered, valid in the cycle after the tick word is taken. Throughput:
// one tick word per cycle while result.ready is high; the lanes and the
// oldest-waiting tree are combinational: each decision feeds the next tick.
// Reset (rst, synchronous): all stations idle, no ringer, last ring end at
// zero, configuration at its defaults, no result pending.
// Stall: the result register holds its word while result.ready is low; a
// new tick word is taken in the same cycle the held word leaves, so ticks
// back up only while the receiver stalls.
module line_ring_arbiter (
  input  logic                              clk,
  input  logic                              rst,
  lrarb_tick_if.sink                        tick,
  lrarb_result_if.source                    result,
  input  logic                              cfg_we,
  input  logic [lrarb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lrarb_pkg::CFG_W-1:0]       cfg_data
);

  localparam int N = lrarb_pkg::STATION_COUNT;

  logic                               accept;
  logic [lrarb_pkg::GAP_W-1:0]        silence_gap;
  logic [lrarb_pkg::GAP_W-1:0]        ambience_gap;
  logic [lrarb_pkg::BITS_W-1:0]       ambience_mask;
  logic [lrarb_pkg::TIME_W-1:0]       last_end;
  logic [lrarb_pkg::TIME_W-1:0]       last_end_next;
  logic [N-1:0]                       called;
  logic [N-1:0]                       hook;
  logic [N-1:0]                       ambience;
  logic [N-1:0]                       grant;
  logic [N-1:0]                       leave_play;
  logic [N-1:0]                       playing;
  logic [lrarb_pkg::STATES_W-1:0]     states_next;
  lrarb_pkg::lane_status_t            lanes [N];
  lrarb_pkg::arb_result_t             res;

  // take a tick word when the result register is free or draining
  assign tick.ready = !result.valid || result.ready;
  assign accept     = tick.valid && tick.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      silence_gap   <= lrarb_pkg::SILENCE_GAP_RST;
      ambience_gap  <= lrarb_pkg::AMBIENCE_GAP_RST;
      ambience_mask <= lrarb_pkg::AMBIENCE_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lrarb_pkg::REG_SILENCE_GAP:   silence_gap   <= cfg_data;
        lrarb_pkg::REG_AMBIENCE_GAP:  ambience_gap  <= cfg_data;
        lrarb_pkg::REG_AMBIENCE_MASK: ambience_mask <= cfg_data[lrarb_pkg::BITS_W-1:0];
        default: ;
      endcase
    end
  end

  // per-station inputs; stations past the eighth see nothing
  for (genvar i = 0; i < N; i++) begin : g_bits
    if (i < lrarb_pkg::BITS_W) begin : g_wired
      assign called[i]   = tick.called_bits[i];
      assign hook[i]     = tick.hook_bits[i];
      assign ambience[i] = ambience_mask[i];
    end else begin : g_unwired
      assign called[i]   = 1'b0;
      assign hook[i]     = 1'b0;
      assign ambience[i] = 1'b0;
    end
  end

  // station lanes
  for (genvar i = 0; i < N; i++) begin : g_lane
    lrarb_lane u_lane (
      .clk          (clk),
      .rst          (rst),
      .en           (accept),
      .now_ms       (tick.now_ms),
      .called       (called[i]),
      .hook         (hook[i]),
      .code_playing (tick.code_playing),
      .ambience     (ambience[i]),
      .grant        (grant[i]),
      .status       (lanes[i])
    );
    assign leave_play[i] = lanes[i].leave_play;
    assign playing[i]    = (lanes[i].mode_cur == lrarb_pkg::MODE_PLAY);
  end

  // ring end time as seen after the lane step
  assign last_end_next = (|leave_play) ? tick.now_ms : last_end;

  // merge stage
  lrarb_merge u_merge (
    .lanes        (lanes),
    .ambience     (ambience),
    .now_ms       (tick.now_ms),
    .last_end     (last_end_next),
    .silence_gap  (silence_gap),
    .ambience_gap (ambience_gap),
    .grant        (grant),
    .res          (res)
  );

  // pack the next station modes
  always_comb begin
    states_next = '0;
    for (int i = 0; i < N && i < lrarb_pkg::STATES_W / 3; i++) begin
      states_next[3*i +: 3] = lanes[i].mode_next;
    end
  end

  // ring end time
  always_ff @(posedge clk) begin
    if (rst) begin
      last_end <= '0;
    end else if (accept) begin
      last_end <= last_end_next;
    end
  end

  // result word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (accept) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  // result word payload
  always_ff @(posedge clk) begin
    if (accept) begin
      result.mode_word    <= states_next;
      result.ringer_valid <= res.busy;
      result.ringer_index <= res.busy ? 3'(res.slot) : 3'd0;
      result.ring_started <= res.started;
    end
  end

  // never more than one station ringing
  a_one_ringer: assert property (@(posedge clk) disable iff (rst)
    $onehot0(playing))
    else $error("more than one station in ring playing");

  // a grant only goes to a single station and only with a start
  a_grant_start: assert property (@(posedge clk) disable iff (rst)
    accept |-> ($onehot0(grant) && ((|grant) == res.started)))
    else $error("grant vector disagrees with ring start");

  // a fresh start always shows a ringer
  a_start_ringer: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.ring_started) |-> result.ringer_valid)
    else $error("ring started without a ringer");

  // every taken tick produces a result word next cycle
  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> result.valid)
    else $error("tick word taken but no result word");

endmodule

// ===== sim/lrarb_checker.sv =====
// checker for the line ring arbiter: predicts every result word and compares it with the block
module lrarb_checker (
  input  logic                            clk,
  input  logic                            rst,
  lrarb_tick_if                           tick,
  lrarb_result_if                         result,
  input  logic                            cfg_we,
  input  logic [lrarb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lrarb_pkg::CFG_W-1:0]     cfg_data,
  output int                              err_count,
  output int                              pending,
  output int                              result_count,
  output int                              start_count,
  output int                              amb_start_count
);

  // one predicted result word
  typedef struct packed {
    logic [lrarb_pkg::STATES_W-1:0] states;
    logic                           busy;
    logic [2:0]                     slot;
    logic                           started;
  } ring_word_t;

  // predicted station and ringer state
  lrarb_pkg::mode_t             station_mode [lrarb_pkg::STATION_COUNT];
  logic [lrarb_pkg::TIME_W-1:0] wait_since   [lrarb_pkg::STATION_COUNT];
  logic                         ringing;
  logic [2:0]                   ring_slot;
  logic [lrarb_pkg::TIME_W-1:0] ring_end_ms;

  // predicted configuration
  logic [lrarb_pkg::GAP_W-1:0]  silence_gap;
  logic [lrarb_pkg::GAP_W-1:0]  ambience_gap;
  logic [lrarb_pkg::BITS_W-1:0] amb_mask;

  ring_word_t ring_words_due [$];

  int mismatches = 0;
  int queued     = 0;
  int words_seen = 0;
  int rings      = 0;
  int amb_rings  = 0;

  assign err_count       = mismatches;
  assign pending         = queued;
  assign result_count    = words_seen;
  assign start_count     = rings;
  assign amb_start_count = amb_rings;

  // station i is ambience only if its mask bit exists and is set
  function automatic logic amb_station(int i);
    return (i < lrarb_pkg::BITS_W) ? amb_mask[i] : 1'b0;
  endfunction

  // signed wrap-around test of the time since the last ring ended
  function automatic logic gap_elapsed(logic [lrarb_pkg::TIME_W-1:0] now,
                                       logic [lrarb_pkg::GAP_W-1:0] gap);
    logic [lrarb_pkg::TIME_W-1:0] d;
    logic [lrarb_pkg::TIME_W-1:0] g;
    d = now - ring_end_ms;
    g = {16'd0, gap};
    return (g < d) && (d < lrarb_pkg::GAP_LIMIT);
  endfunction

  // mode change with its side effects on the ringer and the waiting start
  task automatic set_mode(int s, lrarb_pkg::mode_t nxt, logic [lrarb_pkg::TIME_W-1:0] now);
    if (station_mode[s] == nxt) return;
    if (station_mode[s] == lrarb_pkg::MODE_PLAY) begin
      ringing     = 1'b0;
      ring_end_ms = now;
    end
    if (nxt == lrarb_pkg::MODE_WAIT) wait_since[s] = now;
    if (nxt == lrarb_pkg::MODE_PLAY) begin
      ringing   = 1'b1;
      ring_slot = s[2:0];
    end
    station_mode[s] = nxt;
  endtask

  // one tick: station machines in index order, then the ringer choice
  task automatic advance_stations(input logic [lrarb_pkg::TIME_W-1:0] now,
                                  input logic [lrarb_pkg::BITS_W-1:0] called,
                                  input logic [lrarb_pkg::BITS_W-1:0] hook, input logic code,
                                  output ring_word_t w);
    logic                         c;
    logic                         h;
    logic                         all_idle;
    logic [lrarb_pkg::TIME_W-1:0] best_age;
    logic [lrarb_pkg::TIME_W-1:0] age;
    int                           best;
    w = '0;
    for (int i = 0; i < lrarb_pkg::STATION_COUNT; i++) begin
      c = (i < lrarb_pkg::BITS_W) ? called[i] : 1'b0;
      h = (i < lrarb_pkg::BITS_W) ? hook[i] : 1'b0;
      case (station_mode[i])
        lrarb_pkg::MODE_WAIT: begin
          if (!c) set_mode(i, lrarb_pkg::MODE_IDLE, now);
          else if (h) set_mode(i, lrarb_pkg::MODE_TALK, now);
        end
        lrarb_pkg::MODE_PLAY: begin
          if (!c) set_mode(i, lrarb_pkg::MODE_IDLE, now);
          else if (h) set_mode(i, lrarb_pkg::MODE_TALK, now);
          else if (!code) set_mode(i, amb_station(i) ? lrarb_pkg::MODE_IDLE
                                                     : lrarb_pkg::MODE_WAIT, now);
        end
        lrarb_pkg::MODE_TALK: begin
          if (!c || !h) set_mode(i, lrarb_pkg::MODE_HANG, now);
        end
        lrarb_pkg::MODE_HANG: begin
          if (!c && !h) set_mode(i, lrarb_pkg::MODE_IDLE, now);
        end
        default: begin
          if (c) set_mode(i, lrarb_pkg::MODE_WAIT, now);
          else if (h) set_mode(i, lrarb_pkg::MODE_TALK, now);
        end
      endcase
    end

    // oldest waiting station rings, normal ones first, ambience only when all normal are idle
    if (!ringing && gap_elapsed(now, silence_gap)) begin
      best_age = '0;
      best     = -1;
      all_idle = 1'b1;
      for (int i = 0; i < lrarb_pkg::STATION_COUNT; i++) begin
        if (!amb_station(i)) begin
          if (station_mode[i] != lrarb_pkg::MODE_IDLE) all_idle = 1'b0;
          if (station_mode[i] == lrarb_pkg::MODE_WAIT) begin
            age = now - wait_since[i];
            if (age > best_age) begin
              best_age = age;
              best     = i;
            end
          end
        end
      end
      if (all_idle && gap_elapsed(now, ambience_gap)) begin
        for (int i = 0; i < lrarb_pkg::STATION_COUNT; i++) begin
          if (amb_station(i) && station_mode[i] == lrarb_pkg::MODE_WAIT) begin
            age = now - wait_since[i];
            if (age > best_age) begin
              best_age = age;
              best     = i;
            end
          end
        end
      end
      if (best >= 0) begin
        set_mode(best, lrarb_pkg::MODE_PLAY, now);
        w.started = 1'b1;
        rings++;
        if (amb_station(best)) amb_rings++;
      end
    end

    for (int i = 0; i < lrarb_pkg::STATION_COUNT && i < 8; i++)
      w.states[3*i +: 3] = station_mode[i];
    w.busy = ringing;
    w.slot = ringing ? ring_slot : 3'd0;
  endtask

  // watch the ports: config writes, result words, then tick words
  always @(posedge clk) begin
    ring_word_t exp_w;
    ring_word_t got_w;
    ring_word_t new_w;
    if (rst) begin
      for (int i = 0; i < lrarb_pkg::STATION_COUNT; i++) begin
        station_mode[i] = lrarb_pkg::MODE_IDLE;
        wait_since[i]   = '0;
      end
      ringing      = 1'b0;
      ring_slot    = 3'd0;
      ring_end_ms  = '0;
      silence_gap  = lrarb_pkg::SILENCE_GAP_RST;
      ambience_gap = lrarb_pkg::AMBIENCE_GAP_RST;
      amb_mask     = lrarb_pkg::AMBIENCE_MASK_RST;
      ring_words_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lrarb_pkg::REG_SILENCE_GAP:   silence_gap  = cfg_data[lrarb_pkg::GAP_W-1:0];
          lrarb_pkg::REG_AMBIENCE_GAP:  ambience_gap = cfg_data[lrarb_pkg::GAP_W-1:0];
          lrarb_pkg::REG_AMBIENCE_MASK: amb_mask     = cfg_data[lrarb_pkg::BITS_W-1:0];
          default: ;
        endcase
      end

      // a result word leaving the block is checked before the tick taken at this edge
      if (result.valid && result.ready) begin
        got_w = {result.mode_word, result.ringer_valid, result.ringer_index,
                 result.ring_started};
        if (ring_words_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word %0d: states %h ringer %b/%0d started %b",
                     words_seen, got_w.states, got_w.busy, got_w.slot, got_w.started);
        end else begin
          exp_w = ring_words_due.pop_front();
          if (got_w !== exp_w) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word %0d mismatch: states exp %h got %h, ringer exp %b/%0d got %b/%0d, %s",
                       words_seen, exp_w.states, got_w.states, exp_w.busy, exp_w.slot,
                       got_w.busy, got_w.slot,
                       $sformatf("started exp %b got %b", exp_w.started, got_w.started));
          end
        end
        words_seen++;
      end

      if (tick.valid && tick.ready) begin
        advance_stations(tick.now_ms, tick.called_bits, tick.hook_bits, tick.code_playing, new_w);
        ring_words_due.push_back(new_w);
      end
    end
    queued <= ring_words_due.size();
  end

endmodule

// ===== sim/tb_line_ring_arbiter.sv =====
// testbench top for the line ring arbiter: clock, reset, stimulus and verdict
module tb_line_ring_arbiter;

  localparam int TICK_ITEMS  = 1600;
  localparam int PHASES      = 6;
  localparam int CYCLE_LIMIT = 200000;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        cfg_we;
  lrarb_pkg::cfg_reg_t         cfg_index;
  logic [lrarb_pkg::CFG_W-1:0] cfg_data;
  logic                        steady;

  int err_count;
  int pending;
  int result_count;
  int start_count;
  int amb_start_count;
  int cycles = 0;

  // stimulus state: time base and the slowly changing line bits
  logic [lrarb_pkg::TIME_W-1:0] clock_ms;
  logic [lrarb_pkg::BITS_W-1:0] call_state;
  logic [lrarb_pkg::BITS_W-1:0] hook_state;

  lrarb_tick_if   tick ();
  lrarb_result_if result ();

  line_ring_arbiter dut (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lrarb_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .tick            (tick),
    .result          (result),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .err_count       (err_count),
    .pending         (pending),
    .result_count    (result_count),
    .start_count     (start_count),
    .amb_start_count (amb_start_count)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver stalls at random except during the steady stretch
  initial begin
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result.ready <= steady || ($urandom_range(0, 99) >= 17);
    end
  end

  // offer one tick word after random idle cycles and wait until it is taken
  task automatic send_tick(logic [lrarb_pkg::TIME_W-1:0] now, logic [lrarb_pkg::BITS_W-1:0] called,
                           logic [lrarb_pkg::BITS_W-1:0] hook, logic code);
    while (!steady && $urandom_range(0, 99) < 17) begin
      tick.valid <= 1'b0;
      @(posedge clk);
    end
    tick.valid        <= 1'b1;
    tick.now_ms       <= now;
    tick.called_bits  <= called;
    tick.hook_bits    <= hook;
    tick.code_playing <= code;
    @(posedge clk);
    while (!tick.ready) @(posedge clk);
  endtask

  // hold off until every expected word has come back
  task automatic drain();
    tick.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(lrarb_pkg::cfg_reg_t idx, logic [lrarb_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // random walk of the line bits and the time base, with some pure noise words
  task automatic random_tick(int rise_norm, int rise_amb, logic [lrarb_pkg::BITS_W-1:0] amb,
                             int step_lim);
    int roll;
    logic [lrarb_pkg::TIME_W-1:0] step;
    for (int i = 0; i < lrarb_pkg::BITS_W; i++) begin
      if (call_state[i]) call_state[i] = $urandom_range(0, 99) >= 12;
      else call_state[i] = $urandom_range(0, 99) < (amb[i] ? rise_amb : rise_norm);
      if (hook_state[i]) hook_state[i] = $urandom_range(0, 99) >= 25;
      else hook_state[i] = $urandom_range(0, 99) < 5;
    end
    roll = $urandom_range(0, 99);
    if (roll < 6) step = '0;
    else if (roll < 70) step = $urandom_range(1, step_lim / 4);
    else if (roll < 99) step = $urandom_range(1, step_lim);
    else step = $urandom_range(0, 32'h3FFF_FFFF);
    clock_ms = clock_ms + step;
    if ($urandom_range(0, 99) < 6)
      send_tick(clock_ms, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
    else
      send_tick(clock_ms, call_state, hook_state, $urandom_range(0, 99) < 65);
  endtask

  // directed words: {now_ms, called, hook, code_playing}
  logic [48:0] script [21] = '{
    {32'h0000_0000, 8'h00, 8'h00, 1'b0},  // quiet start, gap not passed
    {32'd5000,      8'h00, 8'h01, 1'b0},  // idle off hook goes talking
    {32'd5001,      8'h01, 8'h01, 1'b0},
    {32'd5002,      8'h00, 8'h01, 1'b0},  // call gone, hangup wait
    {32'd5003,      8'h00, 8'h00, 1'b0},  // back to idle
    {32'd6000,      8'hFE, 8'h00, 1'b1},  // stations 1 to 7 wait, age zero never wins
    {32'd6001,      8'hFE, 8'h00, 1'b1},  // tie, lowest index rings
    {32'd6002,      8'hFE, 8'h00, 1'b1},
    {32'd6500,      8'hFE, 8'h00, 1'b0},  // code done, back to waiting
    {32'd8500,      8'hFE, 8'h00, 1'b0},  // gap exactly reached, no ring
    {32'd8501,      8'hFE, 8'h00, 1'b1},  // oldest waiter rings
    {32'd8502,      8'hFE, 8'h04, 1'b1},  // ringer answered
    {32'd8503,      8'hFA, 8'h04, 1'b1},
    {32'd9000,      8'hF8, 8'h00, 1'b1},
    {32'hFFFF_FFFF, 8'hF8, 8'hFF, 1'b1},  // top of time, difference reads negative
    {32'h0000_0000, 8'h00, 8'h00, 1'b0},  // time wraps
    {32'h0000_0001, 8'h00, 8'h00, 1'b0},
    {32'h8000_0000, 8'hFF, 8'h00, 1'b1},
    {32'h8000_0100, 8'hFF, 8'h00, 1'b1},
    {32'h8000_0200, 8'hFE, 8'h00, 1'b1},  // ringer loses its call
    {32'h8000_0200, 8'hFF, 8'h00, 1'b0}
  };

  initial begin
    logic [lrarb_pkg::GAP_W-1:0]  sil;
    logic [lrarb_pkg::GAP_W-1:0]  amb_gap;
    logic [lrarb_pkg::BITS_W-1:0] mask;
    int rise_norm;
    int step_lim;
    rst               <= 1'b1;
    steady            <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= lrarb_pkg::REG_SILENCE_GAP;
    cfg_data          <= '0;
    tick.valid        <= 1'b0;
    tick.now_ms       <= '0;
    tick.called_bits  <= '0;
    tick.hook_bits    <= '0;
    tick.code_playing <= 1'b0;
    call_state = '0;
    hook_state = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at reset configuration
    foreach (script[k]) send_tick(script[k][48:17], script[k][16:9], script[k][8:1], script[k][0]);
    clock_ms = 32'h8000_0200;

    // random part, one configuration per phase
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: begin sil = 16'd2000; amb_gap = 16'd10000; mask = 8'h00; end
        1: begin sil = 16'd0;    amb_gap = 16'd0;     mask = 8'hFF; end
        2: begin sil = 16'hFFFF; amb_gap = 16'hFFFF;  mask = 8'h00; end
        3: begin sil = 16'd300;  amb_gap = 16'd1500;  mask = 8'hF0; end
        4: begin
          sil     = 16'($urandom_range(0, 4000));
          amb_gap = 16'($urandom_range(0, 12000));
          mask    = 8'($urandom_range(0, 255));
        end
        default: begin sil = 16'd1; amb_gap = 16'hFFFF; mask = 8'h0F; end
      endcase
      write_reg(lrarb_pkg::REG_SILENCE_GAP, sil);
      write_reg(lrarb_pkg::REG_AMBIENCE_GAP, amb_gap);
      write_reg(lrarb_pkg::REG_AMBIENCE_MASK, {8'h00, mask});
      cfg_we <= 1'b0;
      // long stretch with no idling on either side
      steady <= (p == 2);
      rise_norm = (p == 3) ? 2 : 10;
      step_lim  = (p == 2) ? 40000 : (p == 5) ? 20000 : 3000;
      for (int n = 0; n < TICK_ITEMS / PHASES; n++) random_tick(rise_norm, 10, mask, step_lim);
    end

    drain();
    steady <= 1'b0;
    $display("covered %0d tick words over %0d configurations, %0d ring starts of which %0d ambience",
             result_count, PHASES + 1, start_count, amb_start_count);
    $display("%0d mismatched words, %0d words still owed", err_count, pending);
    if (err_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/lrarb_pkg.sv
rtl/core/lrarb_if.sv
rtl/core/lrarb_lane.sv
rtl/core/lrarb_merge.sv
rtl/core/line_ring_arbiter.sv
sim/lrarb_checker.sv
sim/tb_line_ring_arbiter.sv
